// File: rtl/gbsc_pkg.sv
package gbsc_pkg;

    // number of axes that take part in calibration (1..3)
    localparam int AXES = 3;
    // axes carried by one report
    localparam int NCH = 3;

    localparam int SAMPLE_W = 16;
    localparam int BIAS_W   = 33;   // Q16.16 signed
    localparam int FACTOR_W = 16;   // Q0.16
    localparam int SQ_W     = 49;   // squared residual, Q.16, after the shift
    localparam int VAR_W    = 52;   // Q36.16
    localparam int CORR_W   = 17;
    localparam int THR_W    = 20;
    localparam int CNT_W    = 8;
    localparam int ATT_W    = 2;
    localparam int IDX_W    = 3;
    localparam int CDATA_W  = 20;

    // input word kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // result kinds
    localparam logic RES_RATES = 1'b0;
    localparam logic RES_DONE  = 1'b1;

    // config register indexes
    localparam logic [IDX_W-1:0] CFG_AVERAGE_FACTOR     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COMPLETE_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RESTART_THRESHOLD  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RESTART_COUNT      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INITIAL_COUNT      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ATTACHMENT         = 3'd5;

    // register defaults
    localparam logic [FACTOR_W-1:0] RST_FACTOR   = 16'd3277;
    localparam logic [THR_W-1:0]    RST_COMPLETE = 20'd1100;
    localparam logic [THR_W-1:0]    RST_RESTART  = 20'd2000;
    localparam logic [CNT_W-1:0]    RST_RCOUNT   = 8'd50;
    localparam logic [CNT_W-1:0]    RST_ICOUNT   = 8'd50;
    localparam logic [ATT_W-1:0]    RST_ATTACH   = 2'd0;

    // attachment code with no meaning, reported as none
    localparam logic [ATT_W-1:0] ATT_UNUSED = 2'd3;
    localparam logic [ATT_W-1:0] ATT_NONE   = 2'd0;

    typedef struct packed {
        logic ld_sample;   // store the report's sample
        logic mul;         // (sample - bias) * factor
        logic upd;         // bias update, residual magnitude
        logic sq;          // residual squared
    } t_lane_ctl;

    typedef struct packed {
        logic sum;         // lane sum minus variance
        logic part;        // partial products with the factor
        logic blend;       // variance update
    } t_merge_ctl;

endpackage

// File: rtl/gbsc_if.sv
interface gbsc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic signed [gbsc_pkg::SAMPLE_W-1:0]  rate_x;
    logic signed [gbsc_pkg::SAMPLE_W-1:0]  rate_y;
    logic signed [gbsc_pkg::SAMPLE_W-1:0]  rate_z;

    modport source (output valid, kind, rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, kind, rate_x, rate_y, rate_z, output ready);
endinterface

interface gbsc_res_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic signed [gbsc_pkg::CORR_W-1:0]  corrected_x;
    logic signed [gbsc_pkg::CORR_W-1:0]  corrected_y;
    logic signed [gbsc_pkg::CORR_W-1:0]  corrected_z;
    logic [gbsc_pkg::ATT_W-1:0]          target_set;

    modport source (output valid, result_kind, corrected_x, corrected_y, corrected_z,
                    target_set, input ready);
    modport sink   (input valid, result_kind, corrected_x, corrected_y, corrected_z,
                    target_set, output ready);
endinterface

interface gbsc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gbsc_pkg::IDX_W-1:0]      index;
    logic [gbsc_pkg::CDATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/gbsc_lane.sv
module gbsc_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gbsc_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [gbsc_pkg::SAMPLE_W-1:0] i_rate,
    input  logic [gbsc_pkg::FACTOR_W-1:0]        i_factor,
    output logic signed [gbsc_pkg::CORR_W-1:0]   o_corrected,
    output logic [gbsc_pkg::SQ_W-1:0]            o_sq
);
    import gbsc_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [BIAS_W-1:0]   r_bias;
    logic signed [50:0]         r_prod;
    logic [32:0]                r_abs;
    logic [SQ_W-1:0]            r_sq;

    logic signed [33:0] w_scaled;     // stored sample, Q16.16
    logic signed [33:0] w_diff;
    logic signed [35:0] w_bias_sum;
    logic signed [35:0] w_resid;
    logic [35:0]        w_mag;
    logic [65:0]        w_square;
    logic signed [34:0] w_cdiff;      // new sample minus bias
    logic signed [34:0] w_ctrunc;

    assign w_scaled   = 34'(signed'({r_sample, 16'b0}));
    assign w_diff     = w_scaled - 34'(r_bias);
    assign w_bias_sum = 36'(r_bias) + 36'(r_prod >>> 16);
    assign w_resid    = w_bias_sum - 36'(w_scaled);
    assign w_mag      = w_resid[35] ? 36'(-w_resid) : 36'(w_resid);
    assign w_square   = r_abs * r_abs;

    // corrected rate, truncated toward zero
    assign w_cdiff  = 35'(signed'({i_rate, 16'b0})) - 35'(r_bias);
    assign w_ctrunc = w_cdiff[34] ? ((w_cdiff + 35'sd65535) >>> 16) : (w_cdiff >>> 16);
    assign o_corrected = w_ctrunc[CORR_W-1:0];
    assign o_sq        = r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_bias   <= '0;
        end else begin
            if (i_ctl.ld_sample) begin
                r_sample <= i_rate;
            end
            if (i_ctl.upd) begin
                r_bias <= w_bias_sum[BIAS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= w_diff * signed'({1'b0, i_factor});
        end
        if (i_ctl.upd) begin
            r_abs <= w_mag[32:0];
        end
        if (i_ctl.sq) begin
            r_sq <= w_square[64:16];
        end
    end

endmodule

// File: rtl/gbsc_merge.sv
module gbsc_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbsc_pkg::t_merge_ctl          i_ctl,
    input  logic [gbsc_pkg::SQ_W-1:0]     i_sq [gbsc_pkg::AXES],
    input  logic [gbsc_pkg::FACTOR_W-1:0] i_factor,
    output logic [gbsc_pkg::VAR_W-1:0]    o_var
);
    import gbsc_pkg::*;

    logic [VAR_W-1:0]    r_var;
    logic signed [52:0]  r_diff;
    logic [41:0]         r_plo;
    logic signed [43:0]  r_phi;

    logic [VAR_W-1:0]    w_sum;
    logic signed [69:0]  w_total;
    logic signed [69:0]  w_step;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < AXES; k++) begin
            w_sum = w_sum + VAR_W'(i_sq[k]);
        end
    end

    // var + floor((sum - var) * f / 2^16), product split at bit 26
    assign w_total = (70'(r_phi) <<< 26) + signed'({28'b0, r_plo});
    assign w_step  = w_total >>> 16;
    assign o_var   = r_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var <= '0;
        end else if (i_ctl.blend) begin
            r_var <= r_var + w_step[VAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_diff <= signed'({1'b0, w_sum}) - signed'({1'b0, r_var});
        end
        if (i_ctl.part) begin
            r_plo <= r_diff[25:0] * i_factor;
            r_phi <= signed'(r_diff[52:26]) * signed'({1'b0, i_factor});
        end
    end

endmodule

// File: rtl/gyro_bias_stillness_calibrator_unit.sv
// Channel   Dir  Word
// i_in      in   kind, rate_x, rate_y, rate_z (report or calibration tick)
// o_res     out  result_kind, corrected_x/y/z, target_set
// i_cfg     in   index, data (register write, always ready)
//
// A report's sample is stored and, once calibrated, the corrected word is
// loaded into the output register at the same edge.
// A tick before completion is accepted in idle and then runs seven steps of
// the per-axis lanes (multiply, bias update, square), the merge unit (sum,
// two partial products, blend) and a check; calibrated ticks are dropped.
// Input is taken only from idle with the output register empty or draining.
// Reset is synchronous; the countdown restarts at the default initial count.
module gyro_bias_stillness_calibrator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gbsc_in_if.sink        i_in,
    gbsc_res_if.source     o_res,
    gbsc_cfg_if.sink       i_cfg
);
    import gbsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_UPD, S_SQ, S_SUM, S_PART, S_BLEND, S_CHECK
    } t_state;

    t_state r_state;

    // config registers; initial_count only matters at reset, which also
    // restores its default, so writes to it are taken and dropped
    logic [FACTOR_W-1:0] r_factor;
    logic [THR_W-1:0]    r_complete;
    logic [THR_W-1:0]    r_restart;
    logic [CNT_W-1:0]    r_rcount;
    logic [ATT_W-1:0]    r_attach;

    logic [CNT_W-1:0]    r_count;
    logic                r_calibrated;

    // output register
    logic                    r_out_valid;
    logic                    r_out_kind;
    logic signed [CORR_W-1:0] r_out_corr [NCH];
    logic [ATT_W-1:0]        r_out_target;

    logic                     w_in_fire;
    logic                     w_report;
    logic [ATT_W-1:0]         w_target;
    t_lane_ctl                w_lane_ctl;
    t_merge_ctl               w_merge_ctl;
    logic signed [SAMPLE_W-1:0] w_rate [NCH];
    logic signed [CORR_W-1:0]   w_corr [NCH];
    logic [SQ_W-1:0]          w_sq [AXES];
    logic [VAR_W-1:0]         w_var;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_report   = (i_in.kind == KIND_REPORT);
    assign w_target   = (r_attach == ATT_UNUSED) ? ATT_NONE : r_attach;

    assign w_rate[0] = i_in.rate_x;
    assign w_rate[1] = i_in.rate_y;
    assign w_rate[2] = i_in.rate_z;

    // step decode
    always_comb begin
        w_lane_ctl.ld_sample = w_in_fire && w_report;
        w_lane_ctl.mul       = (r_state == S_MUL);
        w_lane_ctl.upd       = (r_state == S_UPD);
        w_lane_ctl.sq        = (r_state == S_SQ);
        w_merge_ctl.sum      = (r_state == S_SUM);
        w_merge_ctl.part     = (r_state == S_PART);
        w_merge_ctl.blend    = (r_state == S_BLEND);
    end

    // one lane per calibrated axis; other axes read as zero
    for (genvar g = 0; g < NCH; g++) begin : g_ax
        if (g < AXES) begin : g_lane
            gbsc_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_lane_ctl),
                .i_rate      (w_rate[g]),
                .i_factor    (r_factor),
                .o_corrected (w_corr[g]),
                .o_sq        (w_sq[g])
            );
        end else begin : g_off
            assign w_corr[g] = '0;
        end
    end

    gbsc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_merge_ctl),
        .i_sq     (w_sq),
        .i_factor (r_factor),
        .o_var    (w_var)
    );

    // config write port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor   <= RST_FACTOR;
            r_complete <= RST_COMPLETE;
            r_restart  <= RST_RESTART;
            r_rcount   <= RST_RCOUNT;
            r_attach   <= RST_ATTACH;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_AVERAGE_FACTOR:     r_factor   <= i_cfg.data[FACTOR_W-1:0];
                CFG_COMPLETE_THRESHOLD: r_complete <= i_cfg.data[THR_W-1:0];
                CFG_RESTART_THRESHOLD:  r_restart  <= i_cfg.data[THR_W-1:0];
                CFG_RESTART_COUNT:      r_rcount   <= i_cfg.data[CNT_W-1:0];
                CFG_ATTACHMENT:         r_attach   <= i_cfg.data[ATT_W-1:0];
                default: ;              // initial count, unused indexes
            endcase
        end
    end

    // sequencer, countdown, calibrated flag, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= RST_ICOUNT;
            r_calibrated <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // a rates word loaded in idle takes the register over directly
            if (r_out_valid && o_res.ready && !(w_in_fire && w_report && r_calibrated)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (w_report) begin
                            if (r_calibrated) begin
                                r_out_valid  <= 1'b1;
                                r_out_kind   <= RES_RATES;
                                r_out_corr   <= w_corr;
                                r_out_target <= w_target;
                            end
                        end else if (!r_calibrated) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL:   r_state <= S_UPD;
                S_UPD:   r_state <= S_SQ;
                S_SQ:    r_state <= S_SUM;
                S_SUM:   r_state <= S_PART;
                S_PART:  r_state <= S_BLEND;
                S_BLEND: r_state <= S_CHECK;
                S_CHECK: begin
                    r_state <= S_IDLE;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end else if (w_var < VAR_W'({r_complete, 16'b0})) begin
                        r_calibrated <= 1'b1;
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= RES_DONE;
                        for (int k = 0; k < NCH; k++) begin
                            r_out_corr[k] <= '0;
                        end
                        r_out_target <= w_target;
                    end else if (w_var > VAR_W'({r_restart, 16'b0})) begin
                        r_count <= r_rcount;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out_kind;
    assign o_res.corrected_x = r_out_corr[0];
    assign o_res.corrected_y = r_out_corr[1];
    assign o_res.corrected_z = r_out_corr[2];
    assign o_res.target_set  = r_out_target;

endmodule
